### src/avc_pkg.sv
// shared widths, constants and controller-to-datapath command types
package avc_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam int unsigned PRICE_W  = 24;
  localparam int unsigned VOL_W    = 24;
  localparam int unsigned PROD_W   = PRICE_W + VOL_W;
  localparam int unsigned WSUM_W   = 58;
  localparam int unsigned VSUM_W   = 34;
  localparam int unsigned CURV_W   = 26;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned BARS_W   = 11;
  localparam int unsigned BAR_W    = PRICE_W + VOL_W;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd60;
  localparam logic [BARS_W-1:0]   BARS_MAX     = '1;
  localparam logic [BARS_W-1:0]   MIN_BARS     = 11'd3;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = 5'd24;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [0:0]  REG_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    RD_PREV1 = 2'd0,
    RD_PREV2 = 2'd1,
    RD_DROP  = 2'd2,
    RD_SCAN  = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_PREV1 = 2'd1,
    CAP_PREV2 = 2'd2,
    CAP_DROP  = 2'd3
  } cap_sel_e;

  typedef enum logic [1:0] {
    MUL_NEW   = 2'd0,
    MUL_PREV1 = 2'd1,
    MUL_DROP  = 2'd2
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD     = 3'd0,
    ACC_LOAD     = 3'd1,
    ACC_CLEAR    = 3'd2,
    ACC_ADD      = 3'd3,
    ACC_SUB      = 3'd4,
    ACC_SUB_DROP = 3'd5
  } acc_op_e;

  typedef enum logic [1:0] {
    CURV_HOLD  = 2'd0,
    CURV_FIRST = 2'd1,
    CURV_MID   = 2'd2,
    CURV_LAST  = 2'd3
  } curv_op_e;

  typedef struct packed {
    logic     in_load;
    logic     rd_en;
    rd_sel_e  rd_sel;
    cap_sel_e cap_sel;
    logic     bar_write;
    logic     scan_clear;
    logic     scan_rd;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     sum_store;
    logic     div_start;
    curv_op_e curv_op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bars_ok;
    logic dirty;
    logic scan_last;
    logic div_done;
  } dp_status_t;

endpackage

### src/anchored_vwap_curvature.sv
// top level: second difference of three anchored vwaps, apb look-back register
// Bars enter on the input channel (price_i Q16.8, volume_i) with a valid/ready
// transfer; the curvature (signed Q.8) leaves on the output channel the same way.
// The look-back register sits at apb byte address 0; pready is always high.
// Each bar is handled alone. A bar is written to the ring and, from the third
// bar on, yields one result: a few ring reads and sum updates, then three
// 24-step divisions in turn on one shared divider, which sets the rate. The
// first two bars yield nothing and free the input once written. The first bar
// after a look-back write rebuilds the window sums from the ring, one ring
// read per cycle over the window.
// The result sits in an output register, so the next bar is taken while it waits;
// a bar whose result is ready holds until the output register is free.
// Reset clears the window sums, bar count and ring pointer and sets the look-back
// to 60; the ring itself is not cleared, as only bars written since reset are read.
module anchored_vwap_curvature #(
  parameter int unsigned RING_DEPTH = avc_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [avc_pkg::PRICE_W-1:0]         price_i,
  input  logic [avc_pkg::VOL_W-1:0]           volume_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [avc_pkg::CURV_W-1:0]   curvature_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [avc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [avc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [avc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import avc_pkg::*;

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic                reg_sel;
  logic                cfg_we;
  logic [PERIOD_W-1:0] period;

  assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_PERIOD;
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = (psel && reg_sel) ? APB_DATA_W'(period) : '0;

  avc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  avc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .price_i     (price_i),
    .volume_i    (volume_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[PERIOD_W-1:0]),
    .period_o    (period),
    .curvature_o (curvature_o)
  );

endmodule

### src/avc_ram.sv
// generic single-write, single-read ram with registered read data
module avc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/avc_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit the price width
module avc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [avc_pkg::WSUM_W-1:0]  dividend_i,
  input  logic [avc_pkg::VSUM_W-1:0]  divisor_i,
  output logic [avc_pkg::PRICE_W-1:0] quot_o,
  output logic                        done_o
);
  import avc_pkg::*;

  logic [VSUM_W-1:0]    rem_q;
  logic [PRICE_W-1:0]   quo_q;
  logic [VSUM_W-1:0]    dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [VSUM_W:0]   shifted;
  logic [VSUM_W:0]   trial;
  logic              neg;

  // low dividend bits shift out of the quotient register as quotient bits shift in
  assign shifted = {rem_q, quo_q[PRICE_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign neg     = trial[VSUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[WSUM_W-1:PRICE_W];
      quo_q <= dividend_i[PRICE_W-1:0];
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= neg ? shifted[VSUM_W-1:0] : trial[VSUM_W-1:0];
      quo_q <= {quo_q[PRICE_W-2:0], ~neg};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

### src/avc_datapath.sv
// bar ring, window sums, shared multiplier, divider and curvature accumulator
module avc_datapath #(
  parameter int unsigned RING_DEPTH = avc_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  avc_pkg::dp_cmd_t                   cmd_i,
  output avc_pkg::dp_status_t                status_o,
  input  logic [avc_pkg::PRICE_W-1:0]        price_i,
  input  logic [avc_pkg::VOL_W-1:0]          volume_i,
  input  logic                               cfg_we_i,
  input  logic [avc_pkg::PERIOD_W-1:0]       cfg_wdata_i,
  output logic [avc_pkg::PERIOD_W-1:0]       period_o,
  output logic signed [avc_pkg::CURV_W-1:0]  curvature_o
);
  import avc_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (AW + 2 > BARS_W) ? AW + 2 : BARS_W;
  localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);
  localparam logic [CW-1:0] LOOK_MAX  = CW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] SLOT_LAST = AW'(RING_DEPTH - 1);

  // slot of the bar k places before base, k up to the ring depth
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] base,
                                               input logic [CW-1:0] k);
    logic [CW-1:0] tmp;
    tmp = CW'(base) + DEPTH_C - k;
    if (tmp >= DEPTH_C) begin
      tmp = tmp - DEPTH_C;
    end
    return tmp[AW-1:0];
  endfunction

  logic [PERIOD_W-1:0]     period_q;
  logic                    dirty_q;
  logic [AW-1:0]           ws_q;
  logic [BARS_W-1:0]       bs_q;
  logic [WSUM_W-1:0]       wsum_q;
  logic [VSUM_W-1:0]       vtot_q;
  logic [PRICE_W-1:0]      pn_q, p1_q, p2_q, pd_q;
  logic [VOL_W-1:0]        vn_q, v1_q, vd_q;
  logic [CW-1:0]           j_q;
  logic                    scan_rd_q;
  logic                    scan_mul_q;
  logic [PROD_W-1:0]       mul_q;
  logic [VOL_W-1:0]        mulv_q;
  logic [WSUM_W-1:0]       acc_q;
  logic [VSUM_W-1:0]       vacc_q;
  logic signed [CURV_W-1:0] curv_q;
  logic signed [CURV_W-1:0] curv_out_q;

  logic [CW-1:0]      period_c, look, bs_c, span;
  logic               drop;
  logic [AW-1:0]      raddr;
  logic [BAR_W-1:0]   rdata;
  logic [PRICE_W-1:0] rd_price, mul_a;
  logic [VOL_W-1:0]   rd_vol, mul_b;
  logic               mul_load;
  logic [PRICE_W-1:0] quot, fallback, vw;
  logic               use_fallback;
  logic               div_done;
  logic signed [CURV_W-1:0] vw_ext;

  assign period_c = CW'(period_q);
  assign look     = (period_c > LOOK_MAX) ? LOOK_MAX : period_c;
  assign bs_c     = CW'(bs_q);
  // span = how many bars back the window start lies
  assign span     = (bs_c >= look + CW'(MIN_BARS)) ? look : bs_c - CW'(MIN_BARS);
  assign drop     = bs_c >= look + CW'(MIN_BARS) + CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV1: raddr = ring_back(ws_q, CW'(1));
      RD_PREV2: raddr = ring_back(ws_q, CW'(2));
      RD_DROP:  raddr = ring_back(ws_q, look + CW'(1));
      RD_SCAN:  raddr = ring_back(ws_q, j_q + CW'(1));
      default:  raddr = ring_back(ws_q, CW'(1));
    endcase
  end

  avc_ram #(
    .WIDTH (BAR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bar_write),
    .waddr_i (ws_q),
    .wdata_i ({pn_q, vn_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_price = rdata[BAR_W-1:VOL_W];
  assign rd_vol   = rdata[VOL_W-1:0];

  // config and ring bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      dirty_q    <= 1'b0;
      ws_q       <= '0;
      bs_q       <= '0;
      wsum_q     <= '0;
      vtot_q     <= '0;
      j_q        <= '0;
      scan_rd_q  <= 1'b0;
      scan_mul_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
        dirty_q  <= 1'b1;
      end else if (cmd_i.scan_clear) begin
        dirty_q <= 1'b0;
      end
      if (cmd_i.bar_write) begin
        ws_q <= (ws_q == SLOT_LAST) ? '0 : ws_q + 1'b1;
        if (bs_q != BARS_MAX) begin
          bs_q <= bs_q + 1'b1;
        end
      end
      if (cmd_i.sum_store) begin
        wsum_q <= acc_q;
        vtot_q <= vacc_q;
      end
      if (cmd_i.scan_clear) begin
        j_q <= '0;
      end else if (cmd_i.scan_rd) begin
        j_q <= j_q + 1'b1;
      end
      scan_rd_q  <= cmd_i.scan_rd;
      scan_mul_q <= scan_rd_q;
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      pn_q <= price_i;
      vn_q <= volume_i;
    end
    case (cmd_i.cap_sel)
      CAP_PREV1: begin
        p1_q <= rd_price;
        v1_q <= rd_vol;
      end
      CAP_PREV2: begin
        p2_q <= rd_price;
      end
      CAP_DROP: begin
        pd_q <= rd_price;
        vd_q <= rd_vol;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier, scan reads feed it straight from the ring
  always_comb begin
    mul_load = scan_rd_q | cmd_i.mul_en;
    if (scan_rd_q) begin
      mul_a = rd_price;
      mul_b = rd_vol;
    end else begin
      case (cmd_i.mul_sel)
        MUL_NEW: begin
          mul_a = pn_q;
          mul_b = vn_q;
        end
        MUL_PREV1: begin
          mul_a = p1_q;
          mul_b = v1_q;
        end
        MUL_DROP: begin
          mul_a = pd_q;
          mul_b = vd_q;
        end
        default: begin
          mul_a = pn_q;
          mul_b = vn_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_load) begin
      mul_q  <= mul_a * mul_b;
      mulv_q <= mul_b;
    end
  end

  // window sum accumulator
  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_LOAD: begin
        acc_q  <= wsum_q;
        vacc_q <= vtot_q;
      end
      ACC_CLEAR: begin
        acc_q  <= '0;
        vacc_q <= '0;
      end
      ACC_ADD: begin
        acc_q  <= acc_q + WSUM_W'(mul_q);
        vacc_q <= vacc_q + VSUM_W'(mulv_q);
      end
      ACC_SUB: begin
        acc_q  <= acc_q - WSUM_W'(mul_q);
        vacc_q <= vacc_q - VSUM_W'(mulv_q);
      end
      ACC_SUB_DROP: begin
        if (drop) begin
          acc_q  <= acc_q - WSUM_W'(mul_q);
          vacc_q <= vacc_q - VSUM_W'(mulv_q);
        end
      end
      default: begin
        if (scan_mul_q) begin
          acc_q  <= acc_q + WSUM_W'(mul_q);
          vacc_q <= vacc_q + VSUM_W'(mulv_q);
        end
      end
    endcase
  end

  avc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (vacc_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // empty or zero-volume window takes the end bar's price
  always_comb begin
    case (cmd_i.curv_op)
      CURV_MID: begin
        fallback     = p1_q;
        use_fallback = (span == '0) || (vacc_q == '0);
      end
      CURV_LAST: begin
        fallback     = p2_q;
        use_fallback = (span <= CW'(1)) || (vacc_q == '0);
      end
      default: begin
        fallback     = pn_q;
        use_fallback = (vacc_q == '0);
      end
    endcase
    vw     = use_fallback ? fallback : quot;
    vw_ext = signed'({{(CURV_W - PRICE_W){1'b0}}, vw});
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.curv_op)
      CURV_FIRST: curv_q <= vw_ext;
      CURV_MID:   curv_q <= curv_q - (vw_ext <<< 1);
      CURV_LAST:  curv_q <= curv_q + vw_ext;
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      curv_out_q <= curv_q;
    end
  end

  assign status_o.bars_ok   = bs_q >= MIN_BARS;
  assign status_o.dirty     = dirty_q;
  assign status_o.scan_last = j_q == span;
  assign status_o.div_done  = div_done;

  assign period_o    = period_q;
  assign curvature_o = curv_out_q;

endmodule

### src/avc_ctrl.sv
// sequencer for one bar: ring reads, write, window update, three divisions, result
module avc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  avc_pkg::dp_status_t status_i,
  output avc_pkg::dp_cmd_t    cmd_o
);
  import avc_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_RD1    = 19'h00002,
    ST_RD2    = 19'h00004,
    ST_RD3    = 19'h00008,
    ST_WRITE  = 19'h00010,
    ST_CHECK  = 19'h00020,
    ST_INC0   = 19'h00040,
    ST_INC1   = 19'h00080,
    ST_INC2   = 19'h00100,
    ST_SCAN   = 19'h00200,
    ST_SD1    = 19'h00400,
    ST_SD2    = 19'h00800,
    ST_STORE  = 19'h01000,
    ST_DIV0   = 19'h02000,
    ST_START1 = 19'h04000,
    ST_DIV1   = 19'h08000,
    ST_START2 = 19'h10000,
    ST_DIV2   = 19'h20000,
    ST_EMIT   = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit_ok;

  assign emit_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PREV1;
        state_d      = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_PREV2;
        cmd_o.cap_sel = CAP_PREV1;
        state_d       = ST_RD3;
      end
      ST_RD3: begin
        // bar leaving the window is read before the new bar may overwrite its slot
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_DROP;
        cmd_o.cap_sel = CAP_PREV2;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.cap_sel   = CAP_DROP;
        cmd_o.bar_write = 1'b1;
        state_d         = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.bars_ok) begin
          state_d = ST_IDLE;
        end else if (status_i.dirty) begin
          cmd_o.acc_op     = ACC_CLEAR;
          cmd_o.scan_clear = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          cmd_o.acc_op  = ACC_LOAD;
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_NEW;
          state_d       = ST_INC0;
        end
      end
      ST_INC0: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DROP;
        state_d       = ST_INC1;
      end
      ST_INC1: begin
        cmd_o.acc_op = ACC_SUB_DROP;
        state_d      = ST_INC2;
      end
      ST_INC2: begin
        state_d = ST_STORE;
      end
      ST_SCAN: begin
        // full rebuild of the window sums after a write of the look-back register
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_SCAN;
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_SD1;
        end
      end
      ST_SD1: begin
        state_d = ST_SD2;
      end
      ST_SD2: begin
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.sum_store = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_NEW;
        state_d         = ST_DIV0;
      end
      ST_DIV0: begin
        if (status_i.div_done) begin
          cmd_o.curv_op = CURV_FIRST;
          cmd_o.acc_op  = ACC_SUB;
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_PREV1;
          state_d       = ST_START1;
        end
      end
      ST_START1: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV1;
      end
      ST_DIV1: begin
        if (status_i.div_done) begin
          cmd_o.curv_op = CURV_MID;
          cmd_o.acc_op  = ACC_SUB;
          state_d       = ST_START2;
        end
      end
      ST_START2: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        if (status_i.div_done) begin
          cmd_o.curv_op = CURV_LAST;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
